// File: sv/address_range_breakpoint_unit_assert.svh
// Assertion macros for the address range breakpoint unit.
`ifndef ADDRESS_RANGE_BREAKPOINT_UNIT_ASSERT_SVH
`define ADDRESS_RANGE_BREAKPOINT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Plain property checked at every edge out of reset
`define ARBU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication
`define ARBU_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ARBU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define ARBU_ASSERT(lbl, clk, rstn, prop, msg)
`define ARBU_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define ARBU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: sv/arbu_pkg.sv
// Shared types and constants for the address range breakpoint unit.
`timescale 1ns / 1ps
`default_nettype none

package arbu_pkg;

    localparam int NUM_CLASSES          = 5;
    localparam int RANGES_PER_CLASS_DEF = 16;
    localparam int ADDR_BITS_DEF        = 20;
    localparam int PORT_BITS            = 8;
    localparam int QUEUE_DEPTH          = 2;

    // Request type codes
    localparam logic [2:0] REQ_ADD     = 3'd0;
    localparam logic [2:0] REQ_FLUSH   = 3'd1;
    localparam logic [2:0] REQ_MEM_RD  = 3'd2;
    localparam logic [2:0] REQ_MEM_WR  = 3'd3;
    localparam logic [2:0] REQ_PORT_RD = 3'd4;
    localparam logic [2:0] REQ_PORT_WR = 3'd5;
    localparam logic [2:0] REQ_INSTR   = 3'd6;

    // Breakpoint class codes
    localparam logic [2:0] CLS_MEM_RD  = 3'd0;
    localparam logic [2:0] CLS_MEM_WR  = 3'd1;
    localparam logic [2:0] CLS_PORT_RD = 3'd2;
    localparam logic [2:0] CLS_PORT_WR = 3'd3;
    localparam logic [2:0] CLS_INSTR   = 3'd4;

    // Operation codes handed from front to back
    localparam logic [1:0] OP_NOP   = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_SCAN  = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] cls;
        logic       port;
        logic       instr;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

endpackage

`default_nettype wire

// File: sv/arbu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module arbu_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 80,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/arbu_queue.sv
// Short FIFO between the front decoder and the back executor.
`timescale 1ns / 1ps
`default_nettype none

module arbu_queue #(
    parameter int WIDTH = 70,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    output logic                  valid,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    fill_reg, fill_next;

    assign full  = (fill_reg == CW'(DEPTH));
    assign valid = (fill_reg != '0);
    assign rdata = entry_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + CW'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store beat payload
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: sv/arbu_front.sv
// Front end: accepts input beats and classifies them into commands.
`timescale 1ns / 1ps
`default_nettype none

module arbu_front #(
    parameter int ADDR_BITS = arbu_pkg::ADDR_BITS_DEF,
    localparam int QW = arbu_pkg::CMD_W + 3 * ADDR_BITS
) (
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [2:0]           s_req_type,
    input  wire logic [2:0]           s_bp_class,
    input  wire logic [ADDR_BITS-1:0] s_range_low,
    input  wire logic [ADDR_BITS-1:0] s_range_high,
    input  wire logic [ADDR_BITS-1:0] s_access_addr,
    input  wire logic                 q_full,
    output logic                      q_push,
    output logic      [QW-1:0]        q_wdata
);

    import arbu_pkg::*;

    cmd_t cmd;
    logic cls_ok;

    assign cls_ok  = (s_bp_class < 3'(NUM_CLASSES));
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Map request type to an operation and the class it touches
    always_comb begin
        cmd.op    = OP_NOP;
        cmd.cls   = CLS_MEM_RD;
        cmd.port  = 1'b0;
        cmd.instr = 1'b0;
        case (s_req_type)
            REQ_ADD: begin
                if (cls_ok) begin
                    cmd.op  = OP_ADD;
                    cmd.cls = s_bp_class;
                end
            end
            REQ_FLUSH: begin
                if (cls_ok) begin
                    cmd.op  = OP_FLUSH;
                    cmd.cls = s_bp_class;
                end
            end
            REQ_MEM_RD: begin
                cmd.op  = OP_SCAN;
                cmd.cls = CLS_MEM_RD;
            end
            REQ_MEM_WR: begin
                cmd.op  = OP_SCAN;
                cmd.cls = CLS_MEM_WR;
            end
            REQ_PORT_RD: begin
                cmd.op   = OP_SCAN;
                cmd.cls  = CLS_PORT_RD;
                cmd.port = 1'b1;
            end
            REQ_PORT_WR: begin
                cmd.op   = OP_SCAN;
                cmd.cls  = CLS_PORT_WR;
                cmd.port = 1'b1;
            end
            REQ_INSTR: begin
                cmd.op    = OP_SCAN;
                cmd.cls   = CLS_INSTR;
                cmd.instr = 1'b1;
            end
            default: begin
                cmd.op = OP_NOP;
            end
        endcase
    end

    assign q_wdata = {cmd, s_range_low, s_range_high, s_access_addr};

endmodule

`default_nettype wire

// File: sv/arbu_back.sv
// Back end: executes commands against the range memory and drives results.
`timescale 1ns / 1ps
`default_nettype none
`include "address_range_breakpoint_unit_assert.svh"

module arbu_back #(
    parameter int RANGES_PER_CLASS = arbu_pkg::RANGES_PER_CLASS_DEF,
    parameter int ADDR_BITS        = arbu_pkg::ADDR_BITS_DEF,
    localparam int QW = arbu_pkg::CMD_W + 3 * ADDR_BITS
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_pop,
    input  wire logic [QW-1:0] q_rdata,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_break_hit,
    output logic               m_table_full
);

    import arbu_pkg::*;

    localparam int DEPTH  = NUM_CLASSES * RANGES_PER_CLASS;
    localparam int RAM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(RANGES_PER_CLASS + 1);
    localparam int ENT_W  = 2 * ADDR_BITS;
    localparam logic [ADDR_BITS-1:0] PORT_MASK = ADDR_BITS'((1 << PORT_BITS) - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    // Unpack queue head
    cmd_t                 q_cmd;
    logic [ADDR_BITS-1:0] q_lo;
    logic [ADDR_BITS-1:0] q_hi;
    logic [ADDR_BITS-1:0] q_addr;

    assign {q_cmd, q_lo, q_hi, q_addr} = q_rdata;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg [NUM_CLASSES];
    logic [CNT_W-1:0]     cnt_next [NUM_CLASSES];
    logic                 pending_reg, pending_next;
    logic                 scan_instr_reg, scan_instr_next;
    logic                 scan_port_reg, scan_port_next;
    logic [ADDR_BITS-1:0] scan_addr_reg, scan_addr_next;
    logic [RAM_AW-1:0]    scan_base_reg, scan_base_next;
    logic [CNT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]     issue_idx_reg, issue_idx_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic                 res_brk_reg, res_brk_next;
    logic                 res_full_reg, res_full_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_brk_reg, m_brk_next;
    logic                 m_full_reg, m_full_next;

    logic [CNT_W-1:0]     cur_cnt;
    logic [RAM_AW-1:0]    cls_base;
    logic                 ram_we;
    logic [RAM_AW-1:0]    ram_waddr;
    logic [RAM_AW-1:0]    ram_raddr;
    logic [ENT_W-1:0]     ram_rdata;
    logic [ADDR_BITS-1:0] cmp_a, cmp_lo, cmp_hi;
    logic                 hit_now;
    logic                 scan_done;
    logic                 out_free;

    // Range memory: one entry per stored range, low bound over high bound
    arbu_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({q_lo, q_hi}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Address the head command's class and the scan entry
    assign cur_cnt   = cnt_reg[q_cmd.cls];
    assign cls_base  = RAM_AW'(q_cmd.cls) * RAM_AW'(RANGES_PER_CLASS);
    assign ram_waddr = cls_base + RAM_AW'(cur_cnt);
    assign ram_raddr = scan_base_reg + RAM_AW'(issue_idx_reg);

    // Compare one stored range per cycle; ports look at the low byte only
    assign cmp_a   = scan_port_reg ? (scan_addr_reg & PORT_MASK) : scan_addr_reg;
    assign cmp_lo  = scan_port_reg ? (ram_rdata[ENT_W-1:ADDR_BITS] & PORT_MASK)
                                   : ram_rdata[ENT_W-1:ADDR_BITS];
    assign cmp_hi  = scan_port_reg ? (ram_rdata[ADDR_BITS-1:0] & PORT_MASK)
                                   : ram_rdata[ADDR_BITS-1:0];
    assign hit_now   = cmp_valid_reg && (cmp_a >= cmp_lo) && (cmp_a <= cmp_hi);
    assign scan_done = hit_now || (issue_idx_reg == scan_cnt_reg);
    assign out_free  = !m_valid_reg || m_ready;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pending_next    = pending_reg;
        scan_instr_next = scan_instr_reg;
        scan_port_next  = scan_port_reg;
        scan_addr_next  = scan_addr_reg;
        scan_base_next  = scan_base_reg;
        scan_cnt_next   = scan_cnt_reg;
        issue_idx_next  = issue_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        res_brk_next    = res_brk_reg;
        res_full_next   = res_full_reg;
        m_valid_next    = m_valid_reg;
        m_brk_next      = m_brk_reg;
        m_full_next     = m_full_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;

        // Drop the output beat once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop         = 1'b1;
                    res_brk_next  = 1'b0;
                    res_full_next = 1'b0;
                    case (q_cmd.op)
                        OP_ADD: begin
                            if (cur_cnt == CNT_W'(RANGES_PER_CLASS)) begin
                                res_full_next = 1'b1;
                            end else begin
                                ram_we                = 1'b1;
                                cnt_next[q_cmd.cls] = cur_cnt + CNT_W'(1);
                            end
                            state_next = ST_RESP;
                        end
                        OP_FLUSH: begin
                            cnt_next[q_cmd.cls] = '0;
                            state_next            = ST_RESP;
                        end
                        OP_SCAN: begin
                            scan_instr_next = q_cmd.instr;
                            scan_port_next  = q_cmd.port;
                            scan_addr_next  = q_addr;
                            scan_base_next  = cls_base;
                            scan_cnt_next   = cur_cnt;
                            issue_idx_next  = '0;
                            cmp_valid_next  = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    // Finish: instruction events report and clear the sticky flag; access hits set it
                    if (scan_instr_reg) begin
                        res_brk_next = pending_reg || hit_now;
                        pending_next = 1'b0;
                    end else if (hit_now) begin
                        pending_next = 1'b1;
                    end
                    cmp_valid_next = 1'b0;
                    state_next     = ST_RESP;
                end else begin
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_brk_next   = res_brk_reg;
                    m_full_next  = res_full_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pending_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        scan_instr_reg <= scan_instr_next;
        scan_port_reg  <= scan_port_next;
        scan_addr_reg  <= scan_addr_next;
        scan_base_reg  <= scan_base_next;
        scan_cnt_reg   <= scan_cnt_next;
        issue_idx_reg  <= issue_idx_next;
        res_brk_reg    <= res_brk_next;
        res_full_reg   <= res_full_next;
        m_brk_reg      <= m_brk_next;
        m_full_reg     <= m_full_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_break_hit  = m_brk_reg;
    assign m_table_full = m_full_reg;

    `ARBU_ASSERT_IMPLIES(a_add_has_room, aclk, aresetn, ram_we, cur_cnt < CNT_W'(RANGES_PER_CLASS), "range written into a full class")
    `ARBU_ASSERT_IMPLIES(a_scan_in_bounds, aclk, aresetn, state_reg == ST_SCAN, issue_idx_reg <= scan_cnt_reg, "scan ran past the class count")
    `ARBU_ASSERT_NEXT(a_instr_clears_pending, aclk, aresetn, (state_reg == ST_SCAN) && scan_instr_reg && scan_done, !pending_reg, "instruction event left the sticky hit set")
    `ARBU_ASSERT(a_single_flag, aclk, aresetn, !(m_valid_reg && m_brk_reg && m_full_reg), "break and full flagged on one beat")

endmodule

`default_nettype wire

// File: sv/address_range_breakpoint_unit.sv
// Top level of the address range breakpoint unit.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------------
//   s_      | in        | s_valid / s_ready  | req_type, bp_class, range_low/high, access_addr
//   m_      | out       | m_valid / m_ready  | break_hit, table_full
//
// Add, flush and unused requests go from the idle state to the response state
// in the back end. Access and instruction events scan the n stored ranges of the
// class, at most RANGES_PER_CLASS; the single read port of the range memory
// compares one range per cycle and a hit ends the scan early.
// Reset clears the class counts, the sticky hit flag, the queue and the output;
// the range memory is not cleared, entries above a class count are never compared.
// The two-entry queue keeps taking beats until it is full while the back end scans
// or the output beat waits for m_ready.
`timescale 1ns / 1ps
`default_nettype none

module address_range_breakpoint_unit #(
    parameter int RANGES_PER_CLASS = arbu_pkg::RANGES_PER_CLASS_DEF,
    parameter int ADDR_BITS        = arbu_pkg::ADDR_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [2:0]           s_req_type,
    input  wire logic [2:0]           s_bp_class,
    input  wire logic [ADDR_BITS-1:0] s_range_low,
    input  wire logic [ADDR_BITS-1:0] s_range_high,
    input  wire logic [ADDR_BITS-1:0] s_access_addr,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_break_hit,
    output logic                      m_table_full
);

    import arbu_pkg::*;

    localparam int QW = CMD_W + 3 * ADDR_BITS;

    logic          q_full;
    logic          q_push;
    logic [QW-1:0] q_wdata;
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_rdata;

    // Classify incoming beats
    arbu_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_bp_class    (s_bp_class),
        .s_range_low   (s_range_low),
        .s_range_high  (s_range_high),
        .s_access_addr (s_access_addr),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    // Decouple front and back
    arbu_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .valid   (q_valid),
        .pop     (q_pop),
        .rdata   (q_rdata)
    );

    // Execute commands and drive results
    arbu_back #(
        .RANGES_PER_CLASS (RANGES_PER_CLASS),
        .ADDR_BITS        (ADDR_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_rdata      (q_rdata),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_break_hit  (m_break_hit),
        .m_table_full (m_table_full)
    );

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the address range breakpoint unit.
`timescale 1ns / 1ps

module tb_top;
    import arbu_pkg::*;

    localparam int AW           = ADDR_BITS_DEF;
    localparam int NRANGE       = RANGES_PER_CLASS_DEF;
    localparam int SETTLE_CYCLES = NRANGE + 8;
    localparam int STALL_CYCLES = 400;
    localparam int LIMIT_CYCLES = 300000;

    // Codes the block must ignore
    localparam logic [2:0] REQ_UNUSED    = 3'd7;
    localparam logic [2:0] CLS_UNUSED_LO = 3'd5;
    localparam logic [2:0] CLS_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic brk;
        logic full;
    } flags_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [2:0]    s_req_type = '0;
    logic [2:0]    s_bp_class = '0;
    logic [AW-1:0] s_range_low = '0;
    logic [AW-1:0] s_range_high = '0;
    logic [AW-1:0] s_access_addr = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic          m_break_hit;
    logic          m_table_full;

    // Shadow copy of the breakpoint tables and the sticky hit flag
    logic [AW-1:0] bound_lo [NUM_CLASSES][NRANGE];
    logic [AW-1:0] bound_hi [NUM_CLASSES][NRANGE];
    int            range_count [NUM_CLASSES];
    logic          sticky_hit;

    flags_t        expected_flags[$];
    flags_t        want_flags;
    int            error_count = 0;
    int            cycle_count = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            stall_req = 0;
    int            stall_seen = 0;
    int            stall_left = 0;

    address_range_breakpoint_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_bp_class   (s_bp_class),
        .s_range_low  (s_range_low),
        .s_range_high (s_range_high),
        .s_access_addr(s_access_addr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_break_hit  (m_break_hit),
        .m_table_full (m_table_full)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Drive m_ready: random gaps, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_seen != stall_req) begin
            stall_seen <= stall_req;
            stall_left <= STALL_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_flags.size() == 0) begin
                $error("unexpected result beat: break_hit %0b table_full %0b",
                       m_break_hit, m_table_full);
                error_count++;
            end else begin
                want_flags = expected_flags.pop_front();
                if (m_break_hit !== want_flags.brk) begin
                    $error("break_hit mismatch: expected %0b, actual %0b",
                           want_flags.brk, m_break_hit);
                    error_count++;
                end
                if (m_table_full !== want_flags.full) begin
                    $error("table_full mismatch: expected %0b, actual %0b",
                           want_flags.full, m_table_full);
                    error_count++;
                end
            end
        end
    end

    function automatic void clear_tables();
        for (int c = 0; c < NUM_CLASSES; c++) begin
            range_count[c] = 0;
            for (int i = 0; i < NRANGE; i++) begin
                bound_lo[c][i] = '0;
                bound_hi[c][i] = '0;
            end
        end
        sticky_hit = 1'b0;
    endfunction

    // True when a stored range of the class holds the address
    function automatic logic class_holds(logic [2:0] c, logic [AW-1:0] a, bit byte_only);
        logic [AW-1:0] lo;
        logic [AW-1:0] hi;
        for (int i = 0; i < range_count[c]; i++) begin
            lo = bound_lo[c][i];
            hi = bound_hi[c][i];
            if (byte_only) begin
                if (a[PORT_BITS-1:0] >= lo[PORT_BITS-1:0] &&
                    a[PORT_BITS-1:0] <= hi[PORT_BITS-1:0])
                    return 1'b1;
            end else if (a >= lo && a <= hi) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Advance the shadow state by one request and return the flags it yields
    function automatic flags_t predict_flags(logic [2:0] req, logic [2:0] cls,
                                             logic [AW-1:0] lo, logic [AW-1:0] hi,
                                             logic [AW-1:0] addr);
        flags_t f;
        f = '0;
        case (req)
            REQ_ADD: begin
                if (cls < NUM_CLASSES) begin
                    if (range_count[cls] >= NRANGE) begin
                        f.full = 1'b1;
                    end else begin
                        bound_lo[cls][range_count[cls]] = lo;
                        bound_hi[cls][range_count[cls]] = hi;
                        range_count[cls]++;
                    end
                end
            end
            REQ_FLUSH: begin
                if (cls < NUM_CLASSES)
                    range_count[cls] = 0;
            end
            REQ_MEM_RD:  if (class_holds(CLS_MEM_RD, addr, 1'b0)) sticky_hit = 1'b1;
            REQ_MEM_WR:  if (class_holds(CLS_MEM_WR, addr, 1'b0)) sticky_hit = 1'b1;
            REQ_PORT_RD: if (class_holds(CLS_PORT_RD, addr, 1'b1)) sticky_hit = 1'b1;
            REQ_PORT_WR: if (class_holds(CLS_PORT_WR, addr, 1'b1)) sticky_hit = 1'b1;
            REQ_INSTR: begin
                f.brk = sticky_hit || class_holds(CLS_INSTR, addr, 1'b0);
                sticky_hit = 1'b0;
            end
            default: ;
        endcase
        return f;
    endfunction

    // Pick an address inside a stored range of the class, or a random one
    function automatic logic [AW-1:0] addr_in_class(logic [2:0] c, bit byte_only);
        logic [AW-1:0] a;
        logic [AW-1:0] lo;
        logic [AW-1:0] hi;
        int idx;
        a = AW'($urandom);
        if (range_count[c] == 0)
            return a;
        idx = $urandom_range(range_count[c] - 1);
        lo = bound_lo[c][idx];
        hi = bound_hi[c][idx];
        if (byte_only) begin
            if (lo[PORT_BITS-1:0] <= hi[PORT_BITS-1:0])
                a[PORT_BITS-1:0] = lo[PORT_BITS-1:0] + PORT_BITS'($urandom %
                    (hi[PORT_BITS-1:0] - lo[PORT_BITS-1:0] + 1));
        end else if (lo <= hi) begin
            case ($urandom_range(2))
                0: a = lo;
                1: a = hi;
                default: a = lo + AW'($urandom % (hi - lo + 1));
            endcase
        end
        return a;
    endfunction

    // Offer one beat, hold it until accepted, then record its expected flags
    task automatic send_beat(input logic [2:0] req, input logic [2:0] cls,
                             input logic [AW-1:0] lo, input logic [AW-1:0] hi,
                             input logic [AW-1:0] addr);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_bp_class <= cls;
        s_range_low <= lo;
        s_range_high <= hi;
        s_access_addr <= addr;
        do @(posedge aclk); while (!s_ready);
        expected_flags.insert(expected_flags.size(), predict_flags(req, cls, lo, hi, addr));
    endtask

    // Add a range of random shape: narrow, single point, arbitrary or byte-sized
    task automatic send_add(input logic [2:0] cls);
        logic [AW-1:0] lo;
        logic [AW-1:0] hi;
        lo = AW'($urandom);
        hi = AW'($urandom);
        case ($urandom_range(3))
            0: hi = lo + AW'($urandom_range(4095));
            1: hi = lo;
            2: ;
            default: hi[PORT_BITS-1:0] = lo[PORT_BITS-1:0] + PORT_BITS'($urandom_range(31));
        endcase
        send_beat(REQ_ADD, cls, lo, hi, AW'($urandom));
    endtask

    // Access or instruction event on a class; request codes follow class order
    task automatic send_probe(input logic [2:0] c, input int inside_pct);
        logic [AW-1:0] addr;
        bit byte_only;
        byte_only = (c == CLS_PORT_RD || c == CLS_PORT_WR);
        if ($urandom_range(99) < inside_pct)
            addr = addr_in_class(c, byte_only);
        else
            addr = AW'($urandom);
        send_beat(REQ_MEM_RD + c, 3'($urandom), AW'($urandom), AW'($urandom), addr);
    endtask

    task automatic send_random_beat();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            send_add(3'($urandom_range(4)));
        end else if (pick < 28) begin
            send_beat(REQ_FLUSH, 3'($urandom_range(4)), AW'($urandom), AW'($urandom),
                      AW'($urandom));
        end else if (pick < 68) begin
            send_probe(3'($urandom_range(3)), 60);
        end else if (pick < 94) begin
            send_probe(CLS_INSTR, 50);
        end else begin
            case ($urandom_range(2))
                0: send_beat(REQ_UNUSED, 3'($urandom), AW'($urandom), AW'($urandom),
                             AW'($urandom));
                1: send_add(3'($urandom_range(CLS_UNUSED_LO, CLS_UNUSED_HI)));
                default: send_beat(REQ_FLUSH, 3'($urandom_range(CLS_UNUSED_LO, CLS_UNUSED_HI)),
                                   AW'($urandom), AW'($urandom), AW'($urandom));
            endcase
        end
    endtask

    // Drop valid and wait until every expected beat has come back
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        while (expected_flags.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Unused request type and unused classes change nothing; events ignore the class field
    task automatic test_unused_codes();
        send_beat(REQ_UNUSED, CLS_INSTR, '1, '1, '1);
        send_beat(REQ_ADD, CLS_UNUSED_LO, '0, '1, '0);
        send_beat(REQ_ADD, CLS_UNUSED_HI, '0, '1, '1);
        send_beat(REQ_FLUSH, CLS_UNUSED_LO + 3'd1, '1, '0, '0);
        send_beat(REQ_INSTR, CLS_UNUSED_HI, '0, '0, '0);
    endtask

    // Bounds, byte-only port compares, inverted ranges, sticky flag and flush
    task automatic test_range_matching();
        send_beat(REQ_ADD, CLS_MEM_RD, '0, '0, '0);
        send_beat(REQ_ADD, CLS_MEM_WR, '1, '1, '0);
        send_beat(REQ_ADD, CLS_PORT_RD, AW'('h12345), AW'('h000FF), '0);
        send_beat(REQ_ADD, CLS_PORT_WR, AW'('h00080), AW'('hFFF10), '0);
        send_beat(REQ_ADD, CLS_INSTR, AW'('h00100), AW'('h001FF), '0);
        send_beat(REQ_MEM_RD, CLS_MEM_RD, '0, '0, AW'('h00001));
        send_beat(REQ_INSTR, CLS_INSTR, '0, '0, AW'('h80000));
        send_beat(REQ_MEM_RD, CLS_MEM_RD, '0, '0, '0);
        send_beat(REQ_INSTR, CLS_INSTR, '0, '0, AW'('h80000));
        send_beat(REQ_INSTR, CLS_INSTR, '0, '0, AW'('h80000));
        send_beat(REQ_MEM_WR, CLS_MEM_WR, '0, '0, '1);
        send_beat(REQ_INSTR, CLS_INSTR, '0, '0, AW'('h00100));
        send_beat(REQ_PORT_RD, CLS_PORT_RD, '0, '0, AW'('hABC50));
        send_beat(REQ_INSTR, CLS_INSTR, '0, '0, '0);
        send_beat(REQ_PORT_WR, CLS_PORT_WR, '0, '0, AW'('h00090));
        send_beat(REQ_INSTR, CLS_INSTR, '0, '0, AW'('h00200));
        send_beat(REQ_INSTR, CLS_INSTR, '0, '0, AW'('h001FF));
        send_beat(REQ_FLUSH, CLS_INSTR, '0, '0, '0);
        send_beat(REQ_INSTR, CLS_INSTR, '0, '0, AW'('h00150));
    endtask

    // Fill every class, push two adds past full, then probe it
    task automatic test_class_overflow();
        logic [2:0] cls;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            cls = 3'(c);
            send_beat(REQ_FLUSH, cls, AW'($urandom), AW'($urandom), AW'($urandom));
            repeat (NRANGE + 2) send_add(cls);
            repeat (3) send_probe(cls, 80);
            send_probe(CLS_INSTR, 20);
        end
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_random_beat();
    endtask

    // Hold m_ready low for a long stretch while beats keep coming
    task automatic test_output_backpressure();
        int saved_pct;
        saved_pct = send_idle_pct;
        send_idle_pct = 0;
        stall_req <= stall_req + 1;
        repeat (40) send_random_beat();
        send_idle_pct = saved_pct;
    endtask

    initial begin
        clear_tables();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 17;
        recv_idle_pct <= 62;
        test_unused_codes();
        test_range_matching();
        test_class_overflow();
        test_random_traffic(560);
        pause_until_drained();

        send_idle_pct = 62;
        recv_idle_pct <= 17;
        test_random_traffic(560);
        test_output_backpressure();
        pause_until_drained();

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        test_random_traffic(600);
        pause_until_drained();

        if (error_count == 0 && expected_flags.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
